// File: src/s2da_pkg.sv
`timescale 1ns / 1ps

package s2da_pkg;

    // Line format
    localparam int DIGIT_COUNT = 8;
    localparam int SAMPLE_BITS = 24;
    localparam int BCD_BITS    = DIGIT_COUNT * 4;
    localparam int INDEX_BITS  = $clog2(DIGIT_COUNT + 1);

    // Conversion pipeline shape: a fixed number of shift-add-3 steps per stage
    localparam int STEPS_PER_STAGE = 6;
    localparam int STAGE_COUNT     = (SAMPLE_BITS + STEPS_PER_STAGE - 1) / STEPS_PER_STAGE;

    // Character codes
    localparam logic [7:0] ASCII_ZERO    = 8'h30;
    localparam logic [7:0] ASCII_NEWLINE = 8'h0A;

    // Converted line handed from the converter to the serializer
    typedef struct packed {
        logic                valid;
        logic [BCD_BITS-1:0] digits;
    } line_t;

    // One double-dabble step: correct each digit, then shift in one binary bit.
    // The carry out of the top digit is dropped, which keeps the value modulo
    // ten to the power of the digit count.
    function automatic logic [BCD_BITS-1:0] dabble_step(
        input logic [BCD_BITS-1:0] bcd,
        input logic                bit_in
    );
        logic [BCD_BITS-1:0] adj;
        adj = bcd;
        for (int d = 0; d < DIGIT_COUNT; d++)
        begin
            if (adj[d*4 +: 4] >= 4'd5)
            begin
                adj[d*4 +: 4] = adj[d*4 +: 4] + 4'd3;
            end
        end
        return {adj[BCD_BITS-2:0], bit_in};
    endfunction

endpackage

// File: src/s2da_convert.sv
`timescale 1ns / 1ps

module s2da_convert
    import s2da_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   sample_valid,
    output logic                   sample_stall,
    input  logic [SAMPLE_BITS-1:0] sample,
    output line_t                  line,
    input  logic                   line_stall
);

    logic [STAGE_COUNT-1:0] valid_reg;
    logic [STAGE_COUNT-1:0] valid_next;
    logic [BCD_BITS-1:0]    bcd_reg  [STAGE_COUNT];
    logic [BCD_BITS-1:0]    bcd_next [STAGE_COUNT];
    logic [SAMPLE_BITS-1:0] smp_reg  [STAGE_COUNT];
    logic [SAMPLE_BITS-1:0] smp_next [STAGE_COUNT];
    logic [STAGE_COUNT:0]   ready;

    // Build the ready chain from the serializer back to the input
    always_comb
    begin
        ready[STAGE_COUNT] = !line_stall;
        for (int s = STAGE_COUNT - 1; s >= 0; s--)
        begin
            ready[s] = !valid_reg[s] || ready[s+1];
        end
    end

    assign sample_stall = !ready[0];

    // Run each stage's share of shift-add-3 steps on the previous stage's word
    always_comb
    begin
        logic [BCD_BITS-1:0]    b;
        logic [SAMPLE_BITS-1:0] w;
        for (int s = 0; s < STAGE_COUNT; s++)
        begin
            if (s == 0)
            begin
                b             = '0;
                w             = sample;
                valid_next[s] = sample_valid;
            end
            else
            begin
                b             = bcd_reg[s-1];
                w             = smp_reg[s-1];
                valid_next[s] = valid_reg[s-1];
            end
            for (int j = 0; j < STEPS_PER_STAGE; j++)
            begin
                if (s * STEPS_PER_STAGE + j < SAMPLE_BITS)
                begin
                    b = dabble_step(b, w[SAMPLE_BITS-1]);
                    w = w << 1;
                end
            end
            bcd_next[s] = b;
            smp_next[s] = w;
        end
    end

    // Advance valid bits wherever the stage can take a transfer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            for (int s = 0; s < STAGE_COUNT; s++)
            begin
                if (ready[s])
                begin
                    valid_reg[s] <= valid_next[s];
                end
            end
        end
    end

    // Advance stage payload alongside its valid bit
    always_ff @(posedge clk)
    begin
        for (int s = 0; s < STAGE_COUNT; s++)
        begin
            if (ready[s] && valid_next[s])
            begin
                bcd_reg[s] <= bcd_next[s];
                smp_reg[s] <= smp_next[s];
            end
        end
    end

    assign line.valid  = valid_reg[STAGE_COUNT-1];
    assign line.digits = bcd_reg[STAGE_COUNT-1];

endmodule

// File: src/s2da_serialize.sv
`timescale 1ns / 1ps

module s2da_serialize
    import s2da_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  line_t      line,
    output logic       line_stall,
    output logic       char_valid,
    input  logic       char_stall,
    output logic [7:0] text_char,
    output logic       last_char
);

    logic                  buf_valid_reg;
    logic                  buf_valid_next;
    logic [BCD_BITS-1:0]   digits_reg;
    logic [BCD_BITS-1:0]   digits_next;
    logic [INDEX_BITS-1:0] index_reg;
    logic [INDEX_BITS-1:0] index_next;
    logic                  char_valid_reg;
    logic                  char_valid_next;
    logic [7:0]            text_char_reg;
    logic [7:0]            text_char_next;
    logic                  last_char_reg;
    logic                  last_char_next;
    logic                  out_free;
    logic                  at_end;
    logic                  take;

    assign out_free   = !char_valid_reg || !char_stall;
    assign at_end     = (index_reg == INDEX_BITS'(DIGIT_COUNT));
    assign line_stall = buf_valid_reg && !(out_free && at_end);
    assign take       = line.valid && !line_stall;

    // Emit the digits top first, then the newline, while the output register is free
    always_comb
    begin
        buf_valid_next  = buf_valid_reg;
        digits_next     = digits_reg;
        index_next      = index_reg;
        char_valid_next = char_valid_reg;
        text_char_next  = text_char_reg;
        last_char_next  = last_char_reg;
        if (out_free)
        begin
            char_valid_next = buf_valid_reg;
            if (buf_valid_reg)
            begin
                if (at_end)
                begin
                    text_char_next = ASCII_NEWLINE;
                    last_char_next = 1'b1;
                    buf_valid_next = 1'b0;
                    index_next     = '0;
                end
                else
                begin
                    text_char_next = ASCII_ZERO + {4'b0000, digits_reg[BCD_BITS-1 -: 4]};
                    last_char_next = 1'b0;
                    digits_next    = digits_reg << 4;
                    index_next     = index_reg + 1'b1;
                end
            end
        end
        // Load the next line when the buffer is empty or as the current one hands over its newline
        if (take)
        begin
            buf_valid_next = 1'b1;
            digits_next    = line.digits;
            index_next     = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            buf_valid_reg  <= 1'b0;
            index_reg      <= '0;
            char_valid_reg <= 1'b0;
        end
        else
        begin
            buf_valid_reg  <= buf_valid_next;
            index_reg      <= index_next;
            char_valid_reg <= char_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        digits_reg    <= digits_next;
        text_char_reg <= text_char_next;
        last_char_reg <= last_char_next;
    end

    assign char_valid = char_valid_reg;
    assign text_char  = text_char_reg;
    assign last_char  = last_char_reg;

endmodule

// File: src/sample_to_decimal_ascii_line.sv
`timescale 1ns / 1ps
// Channel   Valid         Stall         Payload
// sample    sample_valid  sample_stall  sample[23:0]
// char      char_valid    char_stall    text_char[7:0], last_char
//
// A sample passes four shift-add-3 stages (six binary bits each) into a line
// buffer, and from there each character goes to the output register.
// Each line is eight digits and a newline at one character per cycle while
// char is not stalled, so the char channel's serializer sets the sample rate.
// rst_n clears all valid bits and the character index; no data is held over.
// A stall on char freezes the output register; the conversion stages keep
// filling until the chain backs up to sample_stall. Nothing is lost or repeated.

module sample_to_decimal_ascii_line
    import s2da_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   sample_valid,
    output logic                   sample_stall,
    input  logic [SAMPLE_BITS-1:0] sample,
    output logic                   char_valid,
    input  logic                   char_stall,
    output logic [7:0]             text_char,
    output logic                   last_char
);

    line_t line;
    logic  line_stall;

    // Convert binary to decimal digits
    s2da_convert u_convert (
        .clk          (clk),
        .rst_n        (rst_n),
        .sample_valid (sample_valid),
        .sample_stall (sample_stall),
        .sample       (sample),
        .line         (line),
        .line_stall   (line_stall)
    );

    // Send the digits and the newline one character per transfer
    s2da_serialize u_serialize (
        .clk        (clk),
        .rst_n      (rst_n),
        .line       (line),
        .line_stall (line_stall),
        .char_valid (char_valid),
        .char_stall (char_stall),
        .text_char  (text_char),
        .last_char  (last_char)
    );

endmodule

// File: src/s2da_checker.sv
`timescale 1ns / 1ps

module s2da_checker
    import s2da_pkg::*;
(
    input logic                   clk,
    input logic                   rst_n,
    input logic                   sample_valid,
    input logic                   sample_stall,
    input logic [SAMPLE_BITS-1:0] sample,
    input logic                   char_valid,
    input logic                   char_stall,
    input logic [7:0]             text_char,
    input logic                   last_char
);

    logic [INDEX_BITS-1:0] count_reg;
    logic                  char_xfer;

    assign char_xfer = char_valid && !char_stall;

    // Count characters transferred within the current line
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else if (char_xfer)
        begin
            count_reg <= last_char ? '0 : count_reg + 1'b1;
        end
    end

    // A stalled sample holds
    a_sample_hold: assert property (@(posedge clk) disable iff (!rst_n)
        sample_valid && sample_stall |=> sample_valid && $stable(sample))
        else $error("stalled sample changed");

    // Digits are ASCII decimal characters
    a_digit_range: assert property (@(posedge clk) disable iff (!rst_n)
        char_valid && !last_char |-> text_char >= ASCII_ZERO && text_char <= 8'h39)
        else $error("digit character out of range");

    // The line ends with a newline
    a_newline: assert property (@(posedge clk) disable iff (!rst_n)
        char_valid && last_char |-> text_char == ASCII_NEWLINE)
        else $error("last character is not a newline");

    // The end mark falls exactly after the full digit count
    a_line_length: assert property (@(posedge clk) disable iff (!rst_n)
        char_valid |-> last_char == (count_reg == INDEX_BITS'(DIGIT_COUNT)))
        else $error("line length mismatch");

    // A stalled character holds
    a_char_hold: assert property (@(posedge clk) disable iff (!rst_n)
        char_valid && char_stall |=> char_valid && $stable(text_char) && $stable(last_char))
        else $error("stalled character changed");

endmodule

bind sample_to_decimal_ascii_line s2da_checker u_s2da_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .sample_valid (sample_valid),
    .sample_stall (sample_stall),
    .sample       (sample),
    .char_valid   (char_valid),
    .char_stall   (char_stall),
    .text_char    (text_char),
    .last_char    (last_char)
);

// File: tb/tb_sample_to_decimal_ascii_line.sv
`timescale 1ns / 1ps

module tb_sample_to_decimal_ascii_line;
    import s2da_pkg::*;

    localparam int DIRECTED_COUNT = 22;
    localparam int RANDOM_COUNT   = 440;
    localparam int DRAIN_CYCLES   = 40;
    localparam int CYCLE_LIMIT    = 300000;
    localparam int HOLDOFF_CYCLES = 200;
    localparam int HOLDOFF_AFTER  = 1500;
    localparam int PAUSE_FIRST    = DIRECTED_COUNT;
    localparam int PAUSE_SECOND   = 240;
    localparam int CHARS_PER_LINE = DIGIT_COUNT + 1;
    localparam logic [SAMPLE_BITS-1:0] SAMPLE_MAX = '1;

    typedef struct packed {
        logic [7:0] code;
        logic       is_last;
    } line_char_t;

    typedef enum logic [1:0] {
        STALL_NONE,
        STALL_LIGHT,
        STALL_HEAVY,
        STALL_TOGGLE
    } stall_mode_t;

    logic                   clk          = 1'b0;
    logic                   rst_n        = 1'b0;
    logic                   sample_valid = 1'b0;
    logic [SAMPLE_BITS-1:0] sample       = '0;
    logic                   char_stall   = 1'b0;
    logic                   sample_stall;
    logic                   char_valid;
    logic [7:0]             text_char;
    logic                   last_char;

    logic [SAMPLE_BITS-1:0] pending_samples[$];
    line_char_t             expected_chars[$];
    int                     total_samples;
    int                     items_sent      = 0;
    int                     chars_predicted = 0;
    int                     chars_checked   = 0;
    int                     failures        = 0;
    int                     cycle_count     = 0;

    sample_to_decimal_ascii_line u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .sample_valid (sample_valid),
        .sample_stall (sample_stall),
        .sample       (sample),
        .char_valid   (char_valid),
        .char_stall   (char_stall),
        .text_char    (text_char),
        .last_char    (last_char)
    );

    always #1 clk = ~clk;

    // Expand one sample into its text line: eight digits, then the newline
    function automatic void predict_line(input logic [SAMPLE_BITS-1:0] raw);
        longint unsigned rest;
        logic [3:0]      digits[DIGIT_COUNT];
        rest = raw;
        for (int d = 0; d < DIGIT_COUNT; d++)
        begin
            digits[d] = 4'(rest % 10);
            rest      = rest / 10;
        end
        for (int d = DIGIT_COUNT - 1; d >= 0; d--)
        begin
            expected_chars.push_back('{code: ASCII_ZERO + 8'(digits[d]), is_last: 1'b0});
        end
        expected_chars.push_back('{code: ASCII_NEWLINE, is_last: 1'b1});
    endfunction

    // Sender: bursts of random length, random gaps, drain pauses at two points
    always @(posedge clk or negedge rst_n)
    begin
        int  burst_left;
        int  gap_left;
        bit  accepted;
        int  next_sent;
        int  outstanding;
        if (!rst_n)
        begin
            sample_valid <= 1'b0;
            sample       <= '0;
            burst_left   = 0;
            gap_left     = 0;
        end
        else
        begin
            accepted    = sample_valid && !sample_stall;
            next_sent   = items_sent;
            outstanding = chars_predicted - chars_checked;
            // Record the transfer and queue its expected line
            if (accepted)
            begin
                predict_line(sample);
                chars_predicted <= chars_predicted + CHARS_PER_LINE;
                items_sent      <= items_sent + 1;
                void'(pending_samples.pop_front());
                next_sent   = items_sent + 1;
                outstanding = outstanding + CHARS_PER_LINE;
            end
            // Hold a stalled sample; otherwise pick what to offer next
            if (!(sample_valid && sample_stall))
            begin
                if (gap_left > 0)
                begin
                    gap_left--;
                    sample_valid <= 1'b0;
                end
                else if ((next_sent == PAUSE_FIRST || next_sent == PAUSE_SECOND)
                         && outstanding != 0)
                begin
                    sample_valid <= 1'b0;
                end
                else if (pending_samples.size() > 0)
                begin
                    sample_valid <= 1'b1;
                    sample       <= pending_samples[0];
                    if (burst_left > 0)
                    begin
                        burst_left--;
                    end
                    else
                    begin
                        burst_left = $urandom_range(1, 30);
                        gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 15);
                    end
                end
                else
                begin
                    sample_valid <= 1'b0;
                end
            end
        end
    end

    // Receiver: stall patterns in random stretches, one long hold-off
    always @(posedge clk or negedge rst_n)
    begin
        stall_mode_t stall_mode;
        int          mode_left;
        int          holdoff_left;
        bit          holdoff_done;
        if (!rst_n)
        begin
            char_stall   <= 1'b0;
            stall_mode   = STALL_NONE;
            mode_left    = 0;
            holdoff_left = 0;
            holdoff_done = 1'b0;
        end
        else if (holdoff_left > 0)
        begin
            holdoff_left--;
            char_stall <= 1'b1;
        end
        else if (!holdoff_done && chars_checked >= HOLDOFF_AFTER)
        begin
            holdoff_done = 1'b1;
            holdoff_left = HOLDOFF_CYCLES - 1;
            char_stall   <= 1'b1;
        end
        else
        begin
            if (mode_left == 0)
            begin
                stall_mode = stall_mode_t'($urandom_range(0, 3));
                mode_left  = $urandom_range(10, 80);
            end
            mode_left--;
            case (stall_mode)
                STALL_NONE:   char_stall <= 1'b0;
                STALL_LIGHT:  char_stall <= ($urandom_range(0, 3) == 0);
                STALL_HEAVY:  char_stall <= ($urandom_range(0, 9) < 7);
                STALL_TOGGLE: char_stall <= ~char_stall;
                default:      char_stall <= 1'b0;
            endcase
        end
    end

    // Compare each transferred character with the oldest outstanding one
    always @(posedge clk)
    begin
        line_char_t want;
        if (rst_n && char_valid && !char_stall)
        begin
            if (chars_checked >= chars_predicted)
            begin
                $error("text_char: no character expected, got %0d", text_char);
                failures++;
            end
            else
            begin
                want = expected_chars[chars_checked];
                if (text_char !== want.code)
                begin
                    $error("text_char: expected %0d, actual %0d", want.code, text_char);
                    failures++;
                end
                if (last_char !== want.is_last)
                begin
                    $error("last_char: expected %0d, actual %0d", want.is_last, last_char);
                    failures++;
                end
                chars_checked <= chars_checked + 1;
            end
        end
    end

    // Stop a hung run
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("** sample_to_decimal_ascii_line: FAILED **");
            $finish;
        end
    end

    initial
    begin
        int unsigned           tens[8];
        int                    near_value;
        logic [SAMPLE_BITS-1:0] value;

        tens[0] = 1;
        for (int k = 1; k < 8; k++)
        begin
            tens[k] = tens[k-1] * 10;
        end

        // Directed: extremes, digit rollovers, bit patterns
        pending_samples.push_back('0);
        pending_samples.push_back(24'd1);
        pending_samples.push_back(24'd9);
        pending_samples.push_back(24'd10);
        pending_samples.push_back(24'd99);
        pending_samples.push_back(24'd100);
        pending_samples.push_back(24'd999);
        pending_samples.push_back(24'd1000);
        pending_samples.push_back(24'd99999);
        pending_samples.push_back(24'd100000);
        pending_samples.push_back(24'd999999);
        pending_samples.push_back(24'd1000000);
        pending_samples.push_back(24'd9999999);
        pending_samples.push_back(24'd10000000);
        pending_samples.push_back(24'd12345678);
        pending_samples.push_back(24'd16777214);
        pending_samples.push_back(SAMPLE_MAX);
        pending_samples.push_back(24'h800000);
        pending_samples.push_back(24'h7FFFFF);
        pending_samples.push_back(24'h555555);
        pending_samples.push_back(24'hAAAAAA);
        pending_samples.push_back(24'd11111111);

        // Random: uniform, small, near powers of ten, near full scale, one-hot
        for (int n = 0; n < RANDOM_COUNT; n++)
        begin
            case ($urandom_range(0, 9))
                0, 1, 2, 3: value = SAMPLE_BITS'($urandom);
                4, 5:       value = SAMPLE_BITS'($urandom_range(0, 999));
                6, 7:
                begin
                    near_value = int'(tens[$urandom_range(0, 7)]) + $urandom_range(0, 6) - 3;
                    value      = (near_value < 0) ? '0 : SAMPLE_BITS'(near_value);
                end
                8:          value = SAMPLE_MAX - SAMPLE_BITS'($urandom_range(0, 50));
                default:    value = SAMPLE_BITS'(1) << $urandom_range(0, SAMPLE_BITS - 1);
            endcase
            pending_samples.push_back(value);
        end
        total_samples = pending_samples.size();

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        // Wait for every sample to go in and every line to come out
        while (items_sent < total_samples || chars_checked != chars_predicted)
        begin
            @(posedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (failures == 0)
        begin
            $display("** sample_to_decimal_ascii_line: PASSED **");
        end
        else
        begin
            $display("** sample_to_decimal_ascii_line: FAILED **");
        end
        $finish;
    end

endmodule
